// ===== rtl/id3v2_frame_extractor_core_assert.svh =====
// Assertion macros for the ID3v2 frame extractor core.
// Used by the top level; relies on clk and rst being in scope.
`ifndef ID3V2_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define ID3V2_FRAME_EXTRACTOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ID3FX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ID3FX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/id3fx_pkg.sv =====
// Shared types, codes and tables for the ID3v2 frame extractor.
// No dependencies.
`timescale 1ns / 1ps

package id3fx_pkg;

  localparam int KEY_COUNT   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int SIZE_W      = 29;

  localparam logic [2:0] NO_KEY = 3'd7;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ID3   = 3'd1;
  localparam logic [2:0] ST_EXT_LARGE = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME = 3'd3;
  localparam logic [2:0] ST_TOO_BIG   = 3'd4;

  localparam logic [7:0] EXT_FLAG_BIT = 8'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_EXT,
    PH_FHDR,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tag_start;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [2:0] key_index;
    logic [1:0] text_encoding;
    logic       frame_last;
    logic [2:0] status;
  } result_t;

  // one parsed byte's worth of output: a text beat, an end beat, or both
  typedef struct packed {
    logic       has_text;
    logic       has_end;
    logic [7:0] payload;
    logic [2:0] key_index;
    logic [1:0] text_encoding;
    logic       frame_last;
    logic [2:0] status;
  } event_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h44;
      2'd2:    r = 8'h33;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] wanted_id(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd0:    r = 32'h54504531;
      3'd1:    r = 32'h54414C42;
      3'd2:    r = 32'h54495432;
      3'd3:    r = 32'h54594552;
      3'd4:    r = 32'h54434F4E;
      3'd5:    r = 32'h44495343;
      3'd6:    r = 32'h5452434B;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lookup_key(input logic [31:0] id);
    logic [2:0] r;
    r = NO_KEY;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (wanted_id(3'(k)) == id) r = 3'(k);
    end
    return r;
  endfunction

endpackage

// ===== rtl/id3fx_parser.sv =====
// Front end: walks the tag header, extended header and frame headers,
// producing at most one event per accepted byte. Depends on id3fx_pkg.
`timescale 1ns / 1ps

module id3fx_parser import id3fx_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  item_t  item,
  output logic   ev_valid,
  output event_t ev
);

  phase_t              phase, phase_next;
  logic [3:0]          hdr_idx, hdr_idx_next;
  logic                ext_flag, ext_flag_next;
  logic [SIZE_W-1:0]   body_size, body_size_next;
  logic [SIZE_W-1:0]   body_pos, body_pos_next;
  logic [SIZE_W-1:0]   body_left, body_left_next;
  logic [SIZE_W-1:0]   ext_size, ext_size_next;
  logic [31:0]         frame_id, frame_id_next;
  logic [SIZE_W-1:0]   frame_rem, frame_rem_next;
  logic [2:0]          matched_key, matched_key_next;
  logic [1:0]          frame_enc, frame_enc_next;
  logic [2:0]          walk, walk_next;

  logic [7:0]          b;
  logic                body_step, enter_fh, fhdr_stop;
  logic                text_hit, end_hit;
  logic [2:0]          end_status;
  logic                key_ok;

  assign b      = item.data_byte;
  assign key_ok = ({1'b0, matched_key} < 4'(KEY_COUNT));

  always_comb begin
    phase_t            cur_phase;
    logic [3:0]        cur_idx;
    logic [SIZE_W-1:0] cur_bsize;
    logic              cur_flag;
    logic [2:0]        cur_walk;
    cur_phase = item.tag_start ? PH_HEADER : phase;
    cur_idx   = item.tag_start ? 4'd0 : hdr_idx;
    cur_bsize = item.tag_start ? '0 : body_size;
    cur_flag  = item.tag_start ? 1'b0 : ext_flag;
    cur_walk  = item.tag_start ? ST_OK : walk;

    phase_next       = cur_phase;
    hdr_idx_next     = cur_idx;
    ext_flag_next    = cur_flag;
    body_size_next   = cur_bsize;
    body_pos_next    = body_pos;
    body_left_next   = body_left;
    ext_size_next    = ext_size;
    frame_id_next    = frame_id;
    frame_rem_next   = frame_rem;
    matched_key_next = matched_key;
    frame_enc_next   = frame_enc;
    walk_next        = cur_walk;
    body_step        = 1'b0;
    enter_fh         = 1'b0;
    fhdr_stop        = 1'b0;
    text_hit         = 1'b0;
    end_hit          = 1'b0;
    end_status       = ST_OK;

    case (cur_phase)
      PH_IDLE: begin
      end
      PH_HEADER: begin
        if (cur_idx < 4'd3 && b != magic_byte(cur_idx[1:0])) begin
          end_hit    = 1'b1;
          end_status = ST_NOT_ID3;
          phase_next = PH_IDLE;
        end else begin
          if (cur_idx == 4'd5) ext_flag_next = b[EXT_FLAG_BIT[2:0]];
          if (cur_idx >= 4'd6) body_size_next = {cur_bsize[SIZE_W-8:0], 7'd0} | SIZE_W'(b);
          if (cur_idx < 4'd9) begin
            hdr_idx_next = cur_idx + 4'd1;
          end else begin
            body_step      = 1'b1;
            body_pos_next  = '0;
            body_left_next = body_size_next;
            if (ext_flag_next) begin
              phase_next    = PH_EXT;
              hdr_idx_next  = 4'd0;
              ext_size_next = '0;
            end else begin
              enter_fh = 1'b1;
            end
          end
        end
      end
      default: begin
        body_step      = 1'b1;
        body_pos_next  = body_pos + SIZE_W'(1);
        body_left_next = body_left - SIZE_W'(1);
        case (cur_phase)
          PH_EXT: begin
            if (cur_idx < 4'd4) begin
              ext_size_next = {ext_size[SIZE_W-8:0], 7'd0} | SIZE_W'(b);
              hdr_idx_next  = cur_idx + 4'd1;
            end
            if (hdr_idx_next == 4'd4) begin
              if (cur_idx < 4'd4 && ext_size_next > cur_bsize) begin
                phase_next = PH_DRAIN;
                walk_next  = ST_EXT_LARGE;
              end else if (body_pos_next >= ext_size_next) begin
                enter_fh = 1'b1;
              end
            end
          end
          PH_FHDR: begin
            if (cur_idx < 4'd4) begin
              if (!(b inside {[8'h41:8'h5A], [8'h30:8'h39]})) begin
                fhdr_stop  = 1'b1;
                phase_next = PH_DRAIN;
                walk_next  = ST_BAD_FRAME;
              end else begin
                frame_id_next = {frame_id[23:0], b};
              end
            end else if (cur_idx < 4'd8) begin
              frame_rem_next = {frame_rem[SIZE_W-8:0], 7'd0} | SIZE_W'(b);
            end
            if (!fhdr_stop) begin
              if (cur_idx < 4'd9) begin
                hdr_idx_next = cur_idx + 4'd1;
              end else if (frame_rem == '0) begin
                phase_next = PH_DRAIN;
                walk_next  = ST_BAD_FRAME;
              end else if (frame_rem > body_left_next) begin
                phase_next = PH_DRAIN;
                walk_next  = ST_TOO_BIG;
              end else begin
                matched_key_next = lookup_key(frame_id);
                phase_next       = PH_PAYLOAD;
                hdr_idx_next     = 4'd0;
              end
            end
          end
          PH_PAYLOAD: begin
            if (cur_idx == 4'd0) begin
              if (key_ok && b <= 8'd3) frame_enc_next = b[1:0];
              else                     matched_key_next = NO_KEY;
              hdr_idx_next = 4'd1;
            end else if (key_ok) begin
              text_hit = 1'b1;
            end
            if (frame_rem != '0) frame_rem_next = frame_rem - SIZE_W'(1);
            if (frame_rem_next == '0) enter_fh = 1'b1;
          end
          default: begin
          end
        endcase
      end
    endcase

    if (enter_fh) begin
      if (body_left_next > SIZE_W'(10)) begin
        phase_next     = PH_FHDR;
        hdr_idx_next   = 4'd0;
        frame_id_next  = '0;
        frame_rem_next = '0;
      end else begin
        phase_next = PH_DRAIN;
        walk_next  = ST_OK;
      end
    end

    if (body_step && phase_next != PH_IDLE && body_left_next == '0) begin
      end_hit    = 1'b1;
      end_status = (phase_next == PH_EXT && hdr_idx_next < 4'd4) ? ST_EXT_LARGE : walk_next;
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    ev.has_text      = text_hit;
    ev.has_end       = end_hit;
    ev.payload       = b;
    ev.key_index     = matched_key;
    ev.text_encoding = frame_enc;
    ev.frame_last    = (frame_rem == SIZE_W'(1));
    ev.status        = end_status;
    ev_valid         = accept && (text_hit || end_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      hdr_idx <= 4'd0;
      walk    <= ST_OK;
    end else if (accept) begin
      phase   <= phase_next;
      hdr_idx <= hdr_idx_next;
      walk    <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ext_flag    <= ext_flag_next;
      body_size   <= body_size_next;
      body_pos    <= body_pos_next;
      body_left   <= body_left_next;
      ext_size    <= ext_size_next;
      frame_id    <= frame_id_next;
      frame_rem   <= frame_rem_next;
      matched_key <= matched_key_next;
      frame_enc   <= frame_enc_next;
    end
  end

endmodule

// ===== rtl/id3fx_queue.sv =====
// Short event queue between the parser and the result stage.
// Depends on id3fx_pkg for the event type.
`timescale 1ns / 1ps

module id3fx_queue import id3fx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  event_t                   wr_data,
  input  logic                     rd_en,
  output event_t                   rd_data,
  output logic                     valid,
  output logic                     full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign rd_data = mem[rd_ptr];
  assign valid   = (count != '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign level   = count;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/id3fx_unpack.sv =====
// Back end: holds one event and hands out its text and end beats in order.
// Depends on id3fx_pkg.
`timescale 1ns / 1ps

module id3fx_unpack import id3fx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  event_t  q_data,
  output logic    q_take,
  input  logic    pop,
  output result_t result,
  output logic    empty
);

  event_t cur;
  logic   pend_text, pend_end;
  logic   last_beat;

  assign empty     = !(pend_text || pend_end);
  assign last_beat = pop && (pend_text ^ pend_end);
  assign q_take    = q_valid && (empty || last_beat);

  always_comb begin
    if (pend_text) begin
      result.kind          = KIND_TEXT;
      result.payload       = cur.payload;
      result.key_index     = cur.key_index;
      result.text_encoding = cur.text_encoding;
      result.frame_last    = cur.frame_last;
      result.status        = ST_OK;
    end else begin
      result.kind          = KIND_END;
      result.payload       = 8'd0;
      result.key_index     = 3'd0;
      result.text_encoding = 2'd0;
      result.frame_last    = 1'b0;
      result.status        = cur.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_text <= 1'b0;
      pend_end  <= 1'b0;
    end else if (q_take) begin
      pend_text <= q_data.has_text;
      pend_end  <= q_data.has_end;
    end else if (pop && !empty) begin
      if (pend_text) pend_text <= 1'b0;
      else           pend_end  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) cur <= q_data;
  end

endmodule

// ===== rtl/id3v2_frame_extractor_core.sv =====
// ID3v2 tag frame extractor: top level joining parser, event queue and
// result stage. Depends on id3fx_pkg, id3fx_parser, id3fx_queue, id3fx_unpack.
//
// Usage:
//   Input channel: one tag byte per beat (push / full); tag_start marks the
//   first header byte and restarts the parse at any point.
//   Result channel: empty / pop; each beat is either a text byte of a wanted
//   frame (kind 0) or the end-of-tag status (kind 1).
// Throughput: one byte per cycle while the queue is not full. The parser
//   decides each byte combinationally; a byte that yields both a last text
//   byte and the end status costs two result beats.
// Path: the accepting edge writes a byte's event into the queue, and the
//   result stage loads it from the queue when the result stage is free.
// Stalls: parser events wait in a QUEUE_DEPTH-entry queue; full rises when it
//   is full, so a stalled receiver halts input once QUEUE_DEPTH events wait
//   behind the one held in the result stage. Bytes that yield nothing still
//   need a free queue entry to enter.
// Reset: synchronous rst empties the queue and result stage and puts the
//   parser idle, waiting for a byte with tag_start set.
`timescale 1ns / 1ps
`include "id3v2_frame_extractor_core_assert.svh"

module id3v2_frame_extractor_core import id3fx_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic                               accept;
  logic                               ev_valid;
  event_t                             ev;
  event_t                             q_data;
  logic                               q_valid, q_take;
  logic [$clog2(QUEUE_DEPTH_P+1)-1:0] q_level;

  assign accept = push && !full;

  id3fx_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  id3fx_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .rd_en   (q_take),
    .rd_data (q_data),
    .valid   (q_valid),
    .full    (full),
    .level   (q_level)
  );

  id3fx_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take),
    .pop     (pop),
    .result  (result),
    .empty   (empty)
  );

  `ID3FX_ASSERT_NOW(a_level_bound, 1'b1, q_level <= ($clog2(QUEUE_DEPTH_P+1))'(QUEUE_DEPTH_P), "queue level beyond depth")
  `ID3FX_ASSERT_NOW(a_end_clean, !empty && result.kind == KIND_END, result.payload == 8'd0 && result.frame_last == 1'b0 && result.key_index == 3'd0, "end beat carries text fields")
  `ID3FX_ASSERT_NOW(a_text_key, !empty && result.kind == KIND_TEXT, result.status == ST_OK && result.key_index < 3'(KEY_COUNT), "text beat with bad key or status")
  `ID3FX_ASSERT_NEXT(a_queue_feeds, empty && q_valid, !empty, "queued event not loaded")

endmodule

// ===== bench/tb_id3v2_frame_extractor_core.sv =====
// Self-checking bench for id3v2_frame_extractor_core: directed and random ID3v2 tags
// are pushed one byte per beat while a tracking model predicts every result beat.
// Depends on id3fx_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_id3v2_frame_extractor_core;
  import id3fx_pkg::*;

  localparam int          ITEM_TARGET   = 1750;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          TAIL_CYCLES   = 40;
  localparam logic [7:0]  EXT_TAG       = 8'h01 << EXT_FLAG_BIT;
  localparam logic [7:0]  TAG_MAGIC [3] = '{"I", "D", "3"};
  localparam logic [31:0] FRAME_IDS [KEY_COUNT] =
    '{"TPE1", "TALB", "TIT2", "TYER", "TCON", "DISC", "TRCK"};

  logic    clk = 1'b0;
  logic    rst, push, full, empty, pop;
  item_t   item;
  result_t result;

  always #2 clk = ~clk;

  id3v2_frame_extractor_core dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result
  );

  // tracking model of the parser
  phase_t      ph;
  logic [3:0]  hdr_idx;
  logic [7:0]  tag_flags;
  logic [28:0] body_len, body_pos, ext_len, frame_left;
  logic [31:0] frame_id;
  logic [2:0]  frame_key, stop_code;
  logic [1:0]  frame_enc;
  result_t     expected_beats[$];

  int          mismatches = 0;
  int          send_left, tag_bytes;
  bit          send_eager;
  logic [7:0]  body_q[$], tag_q[$];

  function automatic void expect_beat(logic kind, logic [7:0] data, logic [2:0] key,
                                      logic [1:0] enc, logic last, logic [2:0] st);
    result_t r;
    r.kind          = kind;
    r.payload       = data;
    r.key_index     = key;
    r.text_encoding = enc;
    r.frame_last    = last;
    r.status        = st;
    expected_beats.push_back(r);
  endfunction

  function automatic void clear_tag();
    hdr_idx    = '0;
    tag_flags  = '0;
    body_len   = '0;
    body_pos   = '0;
    ext_len    = '0;
    frame_id   = '0;
    frame_left = '0;
    frame_key  = '0;
    frame_enc  = '0;
    stop_code  = ST_OK;
  endfunction

  function automatic void halt_walk(logic [2:0] st);
    ph        = PH_DRAIN;
    stop_code = st;
  endfunction

  // a frame header needs more than ten body bytes left
  function automatic void next_frame();
    if (32'(body_len) - 32'(body_pos) > 32'd10) begin
      ph         = PH_FHDR;
      hdr_idx    = '0;
      frame_id   = '0;
      frame_left = '0;
    end else begin
      halt_walk(ST_OK);
    end
  endfunction

  function automatic void track_byte(logic [7:0] b, logic s);
    int k;
    if (s) begin
      clear_tag();
      ph = PH_HEADER;
    end
    if (ph == PH_IDLE) return;
    if (ph == PH_HEADER) begin
      if (hdr_idx < 3) begin
        if (b != TAG_MAGIC[hdr_idx]) begin
          expect_beat(KIND_END, 8'h00, 3'd0, 2'd0, 1'b0, ST_NOT_ID3);
          ph = PH_IDLE;
          return;
        end
      end else if (hdr_idx == 5) begin
        tag_flags = b;
      end else if (hdr_idx >= 6) begin
        body_len = 29'({body_len, 7'd0} | b);
      end
      if (hdr_idx < 9) begin
        hdr_idx++;
        return;
      end
      body_pos = '0;
      if ((tag_flags & EXT_TAG) != 0) begin
        ph      = PH_EXT;
        hdr_idx = '0;
        ext_len = '0;
      end else begin
        next_frame();
      end
    end else begin
      body_pos++;
      case (ph)
        PH_EXT: begin
          if (hdr_idx < 4) begin
            ext_len = 29'({ext_len, 7'd0} | b);
            hdr_idx++;
            if (hdr_idx == 4 && ext_len > body_len) halt_walk(ST_EXT_LARGE);
          end
          if (ph == PH_EXT && hdr_idx == 4 && body_pos >= ext_len) next_frame();
        end
        PH_FHDR: begin
          if (hdr_idx < 4 && !((b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))) begin
            halt_walk(ST_BAD_FRAME);
          end else begin
            if (hdr_idx < 4) begin
              frame_id = {frame_id[23:0], b};
            end else if (hdr_idx < 8) begin
              frame_left = 29'({frame_left, 7'd0} | b);
            end
            if (hdr_idx < 9) begin
              hdr_idx++;
            end else if (frame_left == 0) begin
              halt_walk(ST_BAD_FRAME);
            end else if (32'(frame_left) > 32'(body_len) - 32'(body_pos)) begin
              halt_walk(ST_TOO_BIG);
            end else begin
              frame_key = NO_KEY;
              for (k = KEY_COUNT - 1; k >= 0; k--) begin
                if (FRAME_IDS[k] == frame_id) frame_key = 3'(k);
              end
              ph      = PH_PAYLOAD;
              hdr_idx = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (hdr_idx == 0) begin
            if (frame_key < KEY_COUNT && b <= 8'd3) begin
              frame_enc = b[1:0];
            end else begin
              frame_key = NO_KEY;
            end
            hdr_idx = 4'd1;
          end else if (frame_key < KEY_COUNT) begin
            expect_beat(KIND_TEXT, b, frame_key, frame_enc, frame_left == 1, ST_OK);
          end
          if (frame_left > 0) frame_left--;
          if (frame_left == 0) next_frame();
        end
        default: ;
      endcase
    end
    if (ph >= PH_EXT && body_pos >= body_len) begin
      expect_beat(KIND_END, 8'h00, 3'd0, 2'd0, 1'b0,
                  (ph == PH_EXT && hdr_idx < 4) ? ST_EXT_LARGE : stop_code);
      ph = PH_IDLE;
    end
  endfunction

  // each run of beats is picked at random to be eager or to have random waits
  function automatic int next_gap(inout int left, inout bit eager);
    if (left == 0) begin
      eager = ($urandom_range(0, 2) == 0);
      left  = $urandom_range(8, 60);
    end
    left--;
    return eager ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_byte(logic [7:0] b, logic s);
    int gap;
    gap = next_gap(send_left, send_eager);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, tag_start: s};
    do @(posedge clk); while (full);
    track_byte(b, s);
  endtask

  function automatic void add_size(logic [27:0] v);
    int i;
    for (i = 3; i >= 0; i--) body_q.push_back({1'b0, v[7*i +: 7]});
  endfunction

  function automatic void add_frame(logic [31:0] id, logic [27:0] size, logic [7:0] enc,
                                    int plen);
    int i;
    for (i = 3; i >= 0; i--) body_q.push_back(id[8*i +: 8]);
    add_size(size);
    body_q.push_back(8'($urandom));
    body_q.push_back(8'($urandom));
    body_q.push_back(enc);
    repeat (plen) body_q.push_back(8'($urandom));
  endfunction

  function automatic void wrap_body(logic [7:0] flags, logic [27:0] size);
    int i;
    tag_q.delete();
    for (i = 0; i < 3; i++) tag_q.push_back(TAG_MAGIC[i]);
    tag_q.push_back(8'($urandom));
    tag_q.push_back(8'($urandom));
    tag_q.push_back(flags);
    for (i = 3; i >= 0; i--) tag_q.push_back({1'b0, size[7*i +: 7]});
    foreach (body_q[j]) tag_q.push_back(body_q[j]);
    body_q.delete();
  endfunction

  // keep = 0 or keep of at least the tag length sends the whole tag, otherwise only its first keep bytes
  task automatic send_tag(int keep);
    int n, i;
    n = (keep > 0 && keep < tag_q.size()) ? keep : tag_q.size();
    for (i = 0; i < n; i++) send_byte(tag_q[i], i == 0);
    tag_bytes += n;
  endtask

  task automatic flag_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d (%s): expected kind %0d byte %02h key %0d enc %0d last %0d st %0d",
               mismatches, what, want.kind, want.payload, want.key_index,
               want.text_encoding, want.frame_last, want.status);
      $display("  got kind %0d byte %02h key %0d enc %0d last %0d st %0d at %0t",
               got.kind, got.payload, got.key_index, got.text_encoding, got.frame_last,
               got.status, $realtime);
    end
  endtask

  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h49, 1'b0);
  endtask

  task automatic test_bad_magic();
    int pos;
    for (pos = 0; pos < 3; pos++) begin
      wrap_body(8'h00, 28'd0);
      tag_q[pos] = (pos == 0) ? 8'hFF : 8'h00;
      send_tag(0);
    end
  endtask

  task automatic test_empty_body();
    wrap_body(8'h00, 28'd0);
    send_tag(0);
    wrap_body(EXT_TAG, 28'd0);
    send_tag(0);
    body_q.push_back(8'h00);
    body_q.push_back(8'h7F);
    wrap_body(EXT_TAG, 28'd2);
    send_tag(0);
  endtask

  task automatic test_ext_header();
    // extended size below four still skips only the size bytes
    add_size(28'd2);
    add_frame("TRCK", 28'd3, 8'd3, 2);
    repeat (11) body_q.push_back(8'h00);
    wrap_body(EXT_TAG, 28'(body_q.size()));
    send_tag(0);
    add_size(28'd8);
    repeat (4) body_q.push_back(8'($urandom));
    add_frame("TPE1", 28'd4, 8'd0, 3);
    wrap_body(EXT_TAG | 8'hBF, 28'(body_q.size()));
    send_tag(0);
    add_size(28'd100);
    repeat (6) body_q.push_back(8'($urandom));
    wrap_body(EXT_TAG, 28'(body_q.size()));
    send_tag(0);
  endtask

  task automatic test_frame_walk();
    int k;
    for (k = 0; k < KEY_COUNT; k++) add_frame(FRAME_IDS[k], 28'(k % 3 + 2), 8'(k % 4), k % 3 + 1);
    add_frame("TXXX", 28'd3, 8'h00, 2);
    add_frame("TIT2", 28'd3, 8'h04, 2);
    add_frame("TIT2", 28'd2, 8'hFF, 1);
    add_frame("TALB", 28'd1, 8'h03, 0);
    add_frame("TYER", 28'd3, 8'h00, 0);
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    repeat (6) body_q.push_back(8'h00);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
    // last text byte and end status from the same byte
    add_frame("DISC", 28'd3, 8'd1, 2);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
  endtask

  task automatic test_walk_stops();
    add_frame("9Z0[", 28'd2, 8'd0, 1);
    repeat (12) body_q.push_back(8'h00);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
    add_frame("@TPE", 28'd2, 8'd0, 1);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
    add_frame("TPE1", 28'd0, 8'd0, 12);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
    add_frame("TALB", 28'd60, 8'd0, 12);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
  endtask

  task automatic test_restart();
    add_frame("TIT2", 28'd6, 8'd0, 5);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(4);
    add_frame("TIT2", 28'd6, 8'd2, 5);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(17);
    add_frame("TCON", 28'd4, 8'd1, 3);
    wrap_body(8'h00, 28'(body_q.size()));
    send_tag(0);
  endtask

  task automatic test_random_tags();
    logic [7:0]  flags, enc;
    logic [31:0] id;
    int          ext, pick, plen, mode, size, i;
    while (tag_bytes < ITEM_TARGET) begin
      flags = 8'($urandom);
      flags[EXT_FLAG_BIT] = ($urandom_range(0, 2) == 0);
      if (flags[EXT_FLAG_BIT]) begin
        ext = $urandom_range(0, 10);
        add_size(28'(ext));
        repeat ((ext > 4) ? ext - 4 : 0) body_q.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 4)) begin
        pick = $urandom_range(0, 9);
        if (pick < KEY_COUNT) begin
          id = FRAME_IDS[pick];
        end else begin
          for (i = 0; i < 4; i++) begin
            pick = $urandom_range(0, 35);
            id   = {id[23:0], (pick < 26) ? 8'("A" + pick) : 8'("0" + pick - 26)};
          end
        end
        enc  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 255))
                                           : 8'($urandom_range(0, 3));
        plen = $urandom_range(0, 10);
        add_frame(id, 28'(plen + 1), enc, plen);
      end
      repeat (($urandom_range(0, 24) == 0) ? $urandom_range(120, 200) : $urandom_range(0, 12))
        body_q.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
      size = body_q.size();
      mode = $urandom_range(0, 13);
      case (mode)
        0:       size += $urandom_range(1, 20);
        1:       size = $urandom_range(0, size);
        default: ;
      endcase
      wrap_body(flags, 28'(size));
      if (mode == 2) tag_q[$urandom_range(0, tag_q.size() - 1)] = 8'($urandom);
      send_tag((mode == 3) ? $urandom_range(1, tag_q.size()) : 0);
      if (mode == 4) repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin : result_checker
    int      gap, left;
    bit      eager;
    result_t want;
    left  = 0;
    eager = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = next_gap(left, eager);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_beats.size() == 0) begin
        flag_mismatch("beat with nothing expected", result, result);
      end else begin
        want = expected_beats.pop_front();
        if (result.kind !== want.kind || result.payload !== want.payload ||
            result.key_index !== want.key_index ||
            result.text_encoding !== want.text_encoding ||
            result.frame_last !== want.frame_last || result.status !== want.status) begin
          flag_mismatch("wrong beat", want, result);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst  <= 1'b1;
    push <= 1'b0;
    pop  <= 1'b0;
    item <= '0;
    ph = PH_IDLE;
    clear_tag();
    send_left  = 0;
    send_eager = 1'b0;
    tag_bytes  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_bad_magic();
    test_empty_body();
    test_ext_header();
    test_frame_walk();
    test_walk_stops();
    test_restart();
    test_random_tags();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
